/* sv/ecbs_pkg.sv */
// ---------------------------------------------------------------------------
// ecbs_pkg
// Shared types and constants of the error code blink sequencer.
// ---------------------------------------------------------------------------
package ecbs_pkg;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // pattern phases
   localparam logic [2:0] PH_LEAD_GAP = 3'd0;
   localparam logic [2:0] PH_LEAD_ON  = 3'd1;
   localparam logic [2:0] PH_LEAD_OFF = 3'd2;
   localparam logic [2:0] PH_BIT_ON   = 3'd3;
   localparam logic [2:0] PH_BIT_OFF  = 3'd4;
   localparam logic [2:0] PH_TAIL_GAP = 3'd5;

   // timing
   localparam int          TICK_W     = 18;
   localparam logic [15:0] UNIT_RESET = 16'd200;

   // register map
   localparam logic REG_UNIT_TICKS = 1'b0;

   // one result word
   typedef struct packed {
      logic led;
      logic pattern_end;
      logic active;
   } ecbs_result_type;

endpackage

/* sv/ecbs_prep.sv */
// ---------------------------------------------------------------------------
// ecbs_prep
// Decodes a loaded code: lead symbol, value to show and its top bit index.
// ---------------------------------------------------------------------------
module ecbs_prep #(
   parameter int CODE_WIDTH = 32,
   parameter int IDX_W      = $clog2(CODE_WIDTH)
) (
   input  logic [CODE_WIDTH-1:0] error_code,
   output logic                  lead_is_long,
   output logic [CODE_WIDTH-1:0] shown_bits,
   output logic [IDX_W-1:0]      top_idx
);

   logic neg;

   // sign, and value to show: the code, or one minus the code when negative
   assign neg          = error_code[CODE_WIDTH-1];
   assign lead_is_long = !neg && (error_code != '0);
   assign shown_bits   = neg ? (CODE_WIDTH'(1) - error_code) : error_code;

   // priority encoder, highest set bit wins, zero gives index 0
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < CODE_WIDTH; i++) begin
         if (shown_bits[i]) begin
            top_idx = IDX_W'(i);
         end
      end
   end

endmodule

/* sv/ecbs_seq.sv */
// ---------------------------------------------------------------------------
// ecbs_seq
// Pattern state and phase timing; advances once per processed word.
// ---------------------------------------------------------------------------
module ecbs_seq
   import ecbs_pkg::*;
#(
   parameter int CODE_WIDTH = 32,
   parameter int IDX_W      = $clog2(CODE_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  kind,
   input  logic                  load_lead_is_long,
   input  logic [CODE_WIDTH-1:0] load_shown_bits,
   input  logic [IDX_W-1:0]      load_top_idx,
   input  logic [15:0]           unit_ticks,
   output ecbs_result_type       result
);

   logic                  showing_ff, showing_in;
   logic [CODE_WIDTH-1:0] shown_ff, shown_in;
   logic                  lead_long_ff, lead_long_in;
   logic [IDX_W-1:0]      top_idx_ff, top_idx_in;
   logic [IDX_W-1:0]      bpos_ff, bpos_in;
   logic [2:0]            phase_ff, phase_in;
   logic [TICK_W-1:0]     ticks_ff, ticks_in;

   logic [TICK_W-1:0] unit_len;
   logic [TICK_W-1:0] long_len;
   logic [TICK_W-1:0] phase_len;
   logic [TICK_W-1:0] ticks_inc;
   logic [IDX_W-1:0]  bpos_dec;
   logic              cur_bit;
   logic              done;
   logic              pat_end;

   // length of the current phase
   assign unit_len  = (unit_ticks == 16'd0) ? TICK_W'(1) : TICK_W'(unit_ticks);
   assign long_len  = unit_len + {unit_len[TICK_W-2:0], 1'b0};
   assign cur_bit   = shown_ff[bpos_ff - IDX_W'(1)];
   assign ticks_inc = ticks_ff + TICK_W'(1);
   assign done      = ticks_inc >= phase_len;
   assign bpos_dec  = (bpos_ff != '0) ? bpos_ff - IDX_W'(1) : bpos_ff;

   always_comb begin
      case (phase_ff)
         PH_LEAD_ON: phase_len = lead_long_ff ? long_len : unit_len;
         PH_BIT_ON:  phase_len = cur_bit ? long_len : unit_len;
         default:    phase_len = unit_len;
      endcase
   end

   // next state
   always_comb begin
      showing_in   = showing_ff;
      shown_in     = shown_ff;
      lead_long_in = lead_long_ff;
      top_idx_in   = top_idx_ff;
      bpos_in      = bpos_ff;
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      pat_end      = 1'b0;
      if (advance) begin
         if (kind == KIND_LOAD) begin
            showing_in   = 1'b1;
            shown_in     = load_shown_bits;
            lead_long_in = load_lead_is_long;
            top_idx_in   = load_top_idx;
            bpos_in      = load_top_idx;
            phase_in     = PH_LEAD_GAP;
            ticks_in     = '0;
         end else if (showing_ff) begin
            ticks_in = done ? '0 : ticks_inc;
            if (done) begin
               case (phase_ff)
                  PH_LEAD_GAP: phase_in = PH_LEAD_ON;
                  PH_LEAD_ON:  phase_in = PH_LEAD_OFF;
                  PH_LEAD_OFF: phase_in = (bpos_ff != '0) ? PH_BIT_ON : PH_TAIL_GAP;
                  PH_BIT_ON:   phase_in = PH_BIT_OFF;
                  PH_BIT_OFF: begin
                     bpos_in  = bpos_dec;
                     phase_in = (bpos_dec != '0) ? PH_BIT_ON : PH_TAIL_GAP;
                  end
                  default: begin
                     pat_end  = 1'b1;
                     bpos_in  = top_idx_ff;
                     phase_in = PH_LEAD_GAP;
                  end
               endcase
            end
         end
      end
   end

   // result word from the updated state
   assign result.led         = showing_in && (phase_in == PH_LEAD_ON || phase_in == PH_BIT_ON);
   assign result.pattern_end = pat_end;
   assign result.active      = showing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         showing_ff   <= 1'b0;
         shown_ff     <= '0;
         lead_long_ff <= 1'b0;
         top_idx_ff   <= '0;
         bpos_ff      <= '0;
         phase_ff     <= PH_LEAD_GAP;
         ticks_ff     <= '0;
      end else begin
         showing_ff   <= showing_in;
         shown_ff     <= shown_in;
         lead_long_ff <= lead_long_in;
         top_idx_ff   <= top_idx_in;
         bpos_ff      <= bpos_in;
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
      end
   end

endmodule

/* sv/error_code_blink_sequencer_unit.sv */
// ---------------------------------------------------------------------------
// error_code_blink_sequencer_unit
// Blinks a signed error code on a status LED as long and short pulses.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: kind 0 loads error_code and restarts the pattern at the
//    leading gap; kind 1 is one timebase tick. Every word gives one rsp word.
//  - rsp channel: led level, pattern_end on the tick that closes one
//    repetition, active once a code has been loaded.
//  - csr port: unit_ticks at byte address 0 (reset 200, 0 acts as 1).
//    Write it only while no word is in flight.
// Pipeline:
//  - a word is taken into the input register; once the output register is
//    free the sequencer updates its state and the result goes into the
//    output register, where rsp_valid rises and the word waits for rsp_ready.
//  - one word per cycle sustained while rsp_ready stays high.
//  - a stalled rsp side holds its word, the input register still takes one
//    more word, then req_ready drops until the output register frees.
// Reset: pattern idle, both pipeline registers empty; output word data not reset.
// ---------------------------------------------------------------------------
module error_code_blink_sequencer_unit
   import ecbs_pkg::*;
#(
   parameter int CODE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [CODE_WIDTH-1:0] req_error_code,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_led,
   output logic                  rsp_pattern_end,
   output logic                  rsp_active,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(CODE_WIDTH);

   logic                  in_valid_ff, in_valid_in;
   logic                  in_kind_ff;
   logic [CODE_WIDTH-1:0] in_code_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   ecbs_result_type       rsp_data_ff;
   logic [15:0]           unit_ticks_ff;

   logic                  out_free;
   logic                  advance;
   logic                  req_take;
   logic                  csr_write;
   logic                  lead_is_long;
   logic [CODE_WIDTH-1:0] shown_bits;
   logic [IDX_W-1:0]      top_idx;
   ecbs_result_type       result;

   // pipeline handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_code_ff <= req_error_code;
      end
   end

   // code decode
   ecbs_prep #(
      .CODE_WIDTH (CODE_WIDTH),
      .IDX_W      (IDX_W)
   ) u_prep (
      .error_code   (in_code_ff),
      .lead_is_long (lead_is_long),
      .shown_bits   (shown_bits),
      .top_idx      (top_idx)
   );

   // sequencer
   ecbs_seq #(
      .CODE_WIDTH (CODE_WIDTH),
      .IDX_W      (IDX_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .kind              (in_kind_ff),
      .load_lead_is_long (lead_is_long),
      .load_shown_bits   (shown_bits),
      .load_top_idx      (top_idx),
      .unit_ticks        (unit_ticks_ff),
      .result            (result)
   );

   // output word register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led         = rsp_data_ff.led;
   assign rsp_pattern_end = rsp_data_ff.pattern_end;
   assign rsp_active      = rsp_data_ff.active;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_RESET;
      end else if (csr_write && csr_paddr[2] == REG_UNIT_TICKS) begin
         unit_ticks_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_UNIT_TICKS) ? {16'd0, unit_ticks_ff} : 32'd0;

endmodule

/* sv/ecbs_checker.sv */
// ---------------------------------------------------------------------------
// ecbs_checker
// Port-level checks of the blink sequencer, bound to the top level.
// ---------------------------------------------------------------------------
module ecbs_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_led,
   input logic rsp_pattern_end,
   input logic rsp_active
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_led, rsp_pattern_end, rsp_active}))
      else $error("rsp word changed while stalled");

   // LED only lights while a code is shown
   a_led_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_led |-> rsp_active)
      else $error("led on while not active");

   // end of a repetition lands in the leading gap, LED off
   a_end_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_end |-> rsp_active && !rsp_led)
      else $error("pattern end without active gap");

   // pipeline empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind error_code_blink_sequencer_unit ecbs_checker u_ecbs_checker (.*);
